@@ sv/stepper_step_pulse_generator_assert.svh @@
// Assertion macros for the stepper pulse generator RTL.
// Included by spg_ctrl, which checks its own control sequencing.
`ifndef STEPPER_STEP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_PULSE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPG_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("spg assertion failed");

// Next-cycle implication, disabled during reset.
`define SPG_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("spg assertion failed");

`endif

@@ sv/spg_pkg.sv @@
// Shared types and constants for the stepper step/direction pulse generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spg_pkg;

  localparam int POS_W       = 32;
  localparam int ACC_W       = 32;
  localparam int HALF_W      = 32;
  localparam int TICK_W      = 16;
  localparam int BL_W        = 16;
  localparam int CNT_W       = $clog2(ACC_W);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_IN_W  = 72;
  localparam int TDATA_OUT_W = 72;

  localparam logic [TICK_W-1:0] TICK_RESET_NS = TICK_W'(5000 * 2);

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LEVEL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BACKLASH     = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_STEP,
    S_REAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic take_rem;
    logic do_step;
    logic do_real;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/spg_mod.sv @@
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on spg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spg_mod
  import spg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ACC_W-1:0]  dividend,
  input  wire logic [HALF_W-1:0] divisor,
  output logic [HALF_W-1:0]      remainder,
  output logic                   done
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [ACC_W-1:0]  dvd;
  logic [HALF_W-1:0] rem;
  logic [HALF_W-1:0] dsr;
  logic [HALF_W:0]   partial;

  assign partial   = {rem, dvd[ACC_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (partial >= {1'b0, dsr}) begin
        rem <= HALF_W'(partial - {1'b0, dsr});
      end else begin
        rem <= partial[HALF_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/spg_ctrl.sv @@
// Tick sequencer: accept, evaluate, reduce, step, update real_pos, publish.
// Depends on spg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_step_pulse_generator_assert.svh"
module spg_ctrl
  import spg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_EVAL;
      S_EVAL: state_next = stat.fire ? S_DIV : S_OUT;
      S_DIV:  if (stat.div_done) state_next = S_STEP;
      S_STEP: state_next = S_REAL;
      S_REAL: state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      S_EVAL: cmd.start_div = stat.fire;
      S_DIV:  cmd.take_rem  = stat.div_done;
      S_STEP: cmd.do_step   = 1'b1;
      S_REAL: cmd.do_real   = 1'b1;
      S_OUT:  cmd.load_out  = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `SPG_ASSERT_NEXT(a_accept_eval, clk, rst, s_tvalid && s_tready, state == S_EVAL)
  `SPG_ASSERT_NEXT(a_fire_div, clk, rst, state == S_EVAL && stat.fire, state == S_DIV)
  `SPG_ASSERT_NEXT(a_div_hold, clk, rst, state == S_DIV && !stat.div_done, state == S_DIV)
  `SPG_ASSERT_NEXT(a_publish, clk, rst, cmd.load_out, m_tvalid && state == S_IDLE)

endmodule
`default_nettype wire

@@ sv/spg_dp.sv @@
// Datapath: configuration registers, accumulator, phase, position tracking, output register.
// Depends on spg_pkg and spg_mod.
`timescale 1ns / 1ps
`default_nettype none
module spg_dp
  import spg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,
  output logic [TDATA_OUT_W-1:0]      m_tdata,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat
);

  logic [TICK_W-1:0] tick_period;
  logic              limit_en;
  logic              limit_level;
  logic [BL_W-1:0]   backlash;

  logic [HALF_W-1:0] half;
  logic              dir_req;
  logic              enabled;
  logic              pos_mode;
  logic [POS_W-1:0]  target;
  logic              flim;
  logic              rlim;

  logic [ACC_W-1:0]  acc;
  logic              phase;
  logic              pin;
  logic              ldir;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  real_pos;
  logic              issued;
  logic              blocked;
  logic              step_up;
  logic              step_dn;

  logic [HALF_W-1:0] rem;
  logic              r_act;
  logic              f_act;
  logic              hold;
  logic              go;
  logic [POS_W-1:0]  diff;
  logic              fire;
  logic              div_done;

  spg_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  (acc),
    .divisor   (half),
    .remainder (rem),
    .done      (div_done)
  );

  assign fire = (half != '0) && (64'(acc) > 64'(half));

  always_comb begin
    stat.fire     = fire;
    stat.div_done = div_done;
  end

  assign r_act = (rlim == limit_level);
  assign f_act = (flim == limit_level);
  assign hold  = limit_en && ((r_act && !f_act && ldir) || (!r_act && f_act && !ldir));
  assign go    = enabled && !(pos_mode && (pos == target));
  assign diff  = pos - real_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_RESET_NS;
      limit_en    <= 1'b0;
      limit_level <= 1'b0;
      backlash    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TICK_PERIOD: tick_period <= cfg_data[TICK_W-1:0];
        REG_LIMIT_EN:    limit_en    <= cfg_data[0];
        REG_LIMIT_LEVEL: limit_level <= cfg_data[0];
        REG_BACKLASH:    backlash    <= cfg_data[BL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      half     <= s_tdata[31:0];
      dir_req  <= s_tdata[32];
      enabled  <= s_tdata[33];
      pos_mode <= s_tdata[34];
      target   <= POS_W'($signed(s_tdata[66:35]));
      flim     <= s_tdata[67];
      rlim     <= s_tdata[68];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      phase    <= 1'b0;
      pin      <= 1'b0;
      ldir     <= 1'b0;
      pos      <= '0;
      real_pos <= '0;
      issued   <= 1'b0;
      blocked  <= 1'b0;
      step_up  <= 1'b0;
      step_dn  <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        acc     <= acc + ACC_W'(tick_period);
        issued  <= 1'b0;
        blocked <= 1'b0;
        step_up <= 1'b0;
        step_dn <= 1'b0;
      end
      if (cmd.take_rem) begin
        acc <= ACC_W'(rem);
      end
      if (cmd.do_step) begin
        if (phase) begin
          phase <= 1'b0;
          pin   <= 1'b0;
          ldir  <= dir_req;
        end else if (go) begin
          phase <= 1'b1;
          if (hold) begin
            blocked <= 1'b1;
          end else begin
            pin    <= 1'b1;
            issued <= 1'b1;
            if (ldir) begin
              pos     <= pos - POS_W'(1);
              step_dn <= 1'b1;
            end else begin
              pos     <= pos + POS_W'(1);
              step_up <= 1'b1;
            end
          end
        end
      end
      if (cmd.do_real) begin
        if (step_dn && ($signed(pos) < $signed(real_pos))) begin
          real_pos <= pos;
        end else if (step_up && ($signed(real_pos) < $signed(pos))
                     && (diff > POS_W'(backlash))) begin
          real_pos <= pos - POS_W'(backlash);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {4'b0000, blocked, issued, real_pos, pos, ldir, pin};
    end
  end

endmodule
`default_nettype wire

@@ sv/stepper_step_pulse_generator.sv @@
// Top level of the stepper step/direction pulse generator.
// Depends on spg_pkg, spg_ctrl, spg_dp.
//
// One input transaction is one timer tick; it yields exactly one result transaction.
// A tick whose accumulator does not pass the half period (or whose half period is zero)
// goes from evaluation straight to the output register; a tick that passes it has its
// accumulator reduced modulo the half period by the bit-serial remainder unit before
// the step and real-position updates. One tick is processed at a time; the result
// waits in an output register, and the next tick is accepted while it waits.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
module stepper_step_pulse_generator
  import spg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // half_period_ns[31:0], direction_request[32], motion_enabled[33], position_mode[34],
  // target_count[66:35], forward_limit_level[67], reverse_limit_level[68], zero[71:69]
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // step_level[0], dir_level[1], position_out[33:2], real_position_out[65:34],
  // step_issued[66], step_blocked[67], zero[71:68]
  output logic [TDATA_OUT_W-1:0]      m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  spg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

@@ tb/stepper_step_pulse_generator_test.sv @@
// Testbench for stepper_step_pulse_generator: timer ticks and register writes are driven
// over the stream and config channels; each result is checked against a local model, or
// a typed result if given. Depends on spg_pkg and the stepper_step_pulse_generator RTL.
`timescale 1ns / 1ps
module stepper_step_pulse_generator_test;
  import spg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);
  localparam int NO_IDLE_TICKS     = 60;
  localparam int ITEMS_PER_SETTING = 150;
  localparam int SETTLE_CYCLES     = 40;

  typedef struct packed {
    logic [2:0]  unused_pad;
    logic        reverse_limit_level;
    logic        forward_limit_level;
    logic [31:0] target_count;
    logic        position_mode;
    logic        motion_enabled;
    logic        direction_request;
    logic [31:0] half_period_ns;
  } tick_t;

  typedef struct packed {
    logic [3:0]  unused_pad;
    logic        step_blocked;
    logic        step_issued;
    logic [31:0] real_position_out;
    logic [31:0] position_out;
    logic        dir_level;
    logic        step_level;
  } pulse_t;

  typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    tick_t                   tick;
    bit                      typed;
    pulse_t                  pulse;
  } row_t;

  typedef struct {
    bit     typed;
    pulse_t pulse;
  } hand_pulse_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;

  // model copy of registers and motor state
  logic [TICK_W-1:0] tick_ns;
  logic              limits_on;
  logic              limit_level;
  logic [BL_W-1:0]   backlash;
  logic [ACC_W-1:0]  accum_ns;
  logic              phase_high;
  logic              step_pin;
  logic              dir_latched;
  logic [POS_W-1:0]  step_count;
  logic [POS_W-1:0]  real_count;

  pulse_t      expected_pulses[$];
  hand_pulse_t hand_pulses[$];
  row_t        directed[$];
  hand_pulse_t hand;
  pulse_t      predicted;
  bit          failed = 1'b0;
  bit          idling_on = 1'b1;
  logic        sticky_dir = 1'b0;

  stepper_step_pulse_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic pulse_t advance_motor(tick_t t);
    pulse_t p;
    logic   rev_active;
    logic   fwd_active;
    logic   held;
    p = '0;
    accum_ns = accum_ns + ACC_W'(tick_ns);
    if (t.half_period_ns != 0 && accum_ns > t.half_period_ns) begin
      accum_ns = accum_ns % t.half_period_ns;
      if (phase_high) begin
        phase_high = 1'b0;
        step_pin = 1'b0;
        dir_latched = t.direction_request;
      end else if (t.motion_enabled && !(t.position_mode && step_count == t.target_count)) begin
        rev_active = (t.reverse_limit_level == limit_level);
        fwd_active = (t.forward_limit_level == limit_level);
        held = limits_on && ((rev_active && !fwd_active && dir_latched) ||
                             (fwd_active && !rev_active && !dir_latched));
        phase_high = 1'b1;
        if (held) begin
          p.step_blocked = 1'b1;
        end else begin
          step_pin = 1'b1;
          p.step_issued = 1'b1;
          if (dir_latched) begin
            step_count = step_count - 1'b1;
            if ($signed(step_count) < $signed(real_count))
              real_count = step_count;
          end else begin
            step_count = step_count + 1'b1;
            if ($signed(real_count) < $signed(step_count) &&
                step_count - real_count > POS_W'(backlash))
              real_count = step_count - POS_W'(backlash);
          end
        end
      end
    end
    p.step_level = step_pin;
    p.dir_level = dir_latched;
    p.position_out = step_count;
    p.real_position_out = real_count;
    return p;
  endfunction

  task automatic check_pulse(pulse_t want, pulse_t got);
    if (got.step_level !== want.step_level) begin
      $error("step_level: expected %0d, got %0d", want.step_level, got.step_level);
      failed = 1'b1;
    end
    if (got.dir_level !== want.dir_level) begin
      $error("dir_level: expected %0d, got %0d", want.dir_level, got.dir_level);
      failed = 1'b1;
    end
    if (got.position_out !== want.position_out) begin
      $error("position_out: expected %0d, got %0d",
             $signed(want.position_out), $signed(got.position_out));
      failed = 1'b1;
    end
    if (got.real_position_out !== want.real_position_out) begin
      $error("real_position_out: expected %0d, got %0d",
             $signed(want.real_position_out), $signed(got.real_position_out));
      failed = 1'b1;
    end
    if (got.step_issued !== want.step_issued) begin
      $error("step_issued: expected %0d, got %0d", want.step_issued, got.step_issued);
      failed = 1'b1;
    end
    if (got.step_blocked !== want.step_blocked) begin
      $error("step_blocked: expected %0d, got %0d", want.step_blocked, got.step_blocked);
      failed = 1'b1;
    end
  endtask

  // check results, then follow register writes and accepted ticks
  always @(posedge clk) begin
    if (rst) begin
      tick_ns = TICK_RESET_NS;
      limits_on = 1'b0;
      limit_level = 1'b0;
      backlash = '0;
      accum_ns = '0;
      phase_high = 1'b0;
      step_pin = 1'b0;
      dir_latched = 1'b0;
      step_count = '0;
      real_count = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pulses.size() == 0) begin
          $error("result transaction with no tick outstanding");
          failed = 1'b1;
        end else begin
          check_pulse(expected_pulses.pop_front(), pulse_t'(m_tdata));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICK_PERIOD: tick_ns = cfg_data[TICK_W-1:0];
          REG_LIMIT_EN:    limits_on = cfg_data[0];
          REG_LIMIT_LEVEL: limit_level = cfg_data[0];
          REG_BACKLASH:    backlash = cfg_data[BL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predicted = advance_motor(tick_t'(s_tdata));
        if (hand_pulses.size() != 0) begin
          hand = hand_pulses.pop_front();
          if (hand.typed)
            predicted = hand.pulse;
        end
        expected_pulses.push_back(predicted);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= !idling_on || $urandom_range(99) >= 22;
  end

  function automatic row_t tick_row(logic [31:0] half, bit dir, bit en, bit pm,
                                    logic [31:0] target, bit flim, bit rlim);
    row_t r;
    r.kind = ROW_TICK;
    r.reg_index = '0;
    r.reg_value = '0;
    r.tick = '0;
    r.tick.half_period_ns = half;
    r.tick.direction_request = dir;
    r.tick.motion_enabled = en;
    r.tick.position_mode = pm;
    r.tick.target_count = target;
    r.tick.forward_limit_level = flim;
    r.tick.reverse_limit_level = rlim;
    r.typed = 1'b0;
    r.pulse = '0;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, bit step, bit dir, logic [31:0] pos,
                                     logic [31:0] real_pos, bit issued, bit blocked);
    r.typed = 1'b1;
    r.pulse = '0;
    r.pulse.step_level = step;
    r.pulse.dir_level = dir;
    r.pulse.position_out = pos;
    r.pulse.real_position_out = real_pos;
    r.pulse.step_issued = issued;
    r.pulse.step_blocked = blocked;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    row_t r;
    r = tick_row('0, 0, 0, 0, '0, 0, 0);
    r.kind = ROW_WRITE;
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned pick;
    t = '0;
    pick = $urandom_range(99);
    if (pick < 5)
      t.half_period_ns = '0;
    else if (pick < 12)
      t.half_period_ns = $urandom;
    else
      t.half_period_ns = $urandom_range(32'(tick_ns) * 3 + 1, 1);
    if ($urandom_range(9) == 0)
      sticky_dir = ~sticky_dir;
    t.direction_request = sticky_dir;
    t.motion_enabled = $urandom_range(19) != 0;
    t.position_mode = $urandom_range(3) == 0;
    if ($urandom_range(3) == 0)
      t.target_count = $urandom;
    else
      t.target_count = step_count + $urandom_range(4) - 2;
    t.forward_limit_level = $urandom_range(1);
    t.reverse_limit_level = $urandom_range(1);
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while (idling_on && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= t;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_pulses();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pulses.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] tick, logic [CFG_DATA_W-1:0] lim_en,
                               logic [CFG_DATA_W-1:0] lim_lvl, logic [CFG_DATA_W-1:0] bl);
    drain_pulses();
    write_reg(REG_TICK_PERIOD, tick);
    write_reg(REG_LIMIT_EN, lim_en);
    write_reg(REG_LIMIT_LEVEL, lim_lvl);
    write_reg(REG_BACKLASH, bl);
  endtask

  task automatic random_phase(logic [CFG_DATA_W-1:0] tick, logic [CFG_DATA_W-1:0] lim_en,
                              logic [CFG_DATA_W-1:0] lim_lvl, logic [CFG_DATA_W-1:0] bl);
    apply_setting(tick, lim_en, lim_lvl, bl);
    for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
      // hold the sender until every result is back
      if (n == ITEMS_PER_SETTING / 2)
        drain_pulses();
      send_tick(random_tick());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(typed_row(tick_row(0, 0, 1, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(tick_row(32'hFFFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF, 1, 1),
                                 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(tick_row(15000, 1, 1, 0, 0, 0, 0), 1, 0, 1, 1, 1, 0));
    directed.push_back(typed_row(tick_row(15000, 1, 1, 0, 0, 0, 0), 1, 0, 1, 1, 0, 0));
    directed.push_back(typed_row(tick_row(15000, 1, 1, 0, 0, 0, 0), 0, 1, 1, 1, 0, 0));
    directed.push_back(typed_row(tick_row(1, 1, 1, 0, 0, 0, 0), 1, 1, 0, 0, 1, 0));
    directed.push_back(typed_row(tick_row(1, 0, 1, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(tick_row(1, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(tick_row(1, 0, 1, 1, 0, 0, 0), 0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(tick_row(1, 0, 1, 1, 32'h8000_0000, 0, 0), 1, 0, 1, 1, 1, 0));
    directed.push_back(typed_row(tick_row(1, 1, 1, 0, 0, 0, 0), 0, 1, 1, 1, 0, 0));
    directed.push_back(typed_row(tick_row(1, 1, 1, 1, 1, 0, 0), 0, 1, 1, 1, 0, 0));
    directed.push_back(reg_row(REG_LIMIT_EN, 16'hFFFF));
    directed.push_back(reg_row(REG_LIMIT_LEVEL, 16'h0001));
    directed.push_back(tick_row(1, 1, 1, 0, 0, 0, 1));
    directed.push_back(tick_row(1, 0, 1, 0, 0, 0, 0));
    directed.push_back(tick_row(1, 0, 1, 0, 0, 1, 0));
    directed.push_back(tick_row(1, 0, 1, 0, 0, 0, 0));
    directed.push_back(tick_row(1, 0, 1, 0, 0, 1, 1));
    directed.push_back(tick_row(1, 1, 1, 0, 0, 0, 0));
    directed.push_back(tick_row(1, 1, 1, 0, 0, 1, 0));
    directed.push_back(reg_row(REG_BACKLASH, 16'hFFFF));
    directed.push_back(reg_row(REG_UNUSED, 16'hFFFF));
    directed.push_back(reg_row(REG_TICK_PERIOD, 16'h0000));
    directed.push_back(tick_row(1, 0, 1, 0, 0, 0, 0));
    directed.push_back(tick_row(0, 0, 1, 0, 0, 0, 0));
    directed.push_back(reg_row(REG_TICK_PERIOD, 16'hFFFF));
    directed.push_back(tick_row(65534, 0, 1, 0, 0, 0, 0));
    directed.push_back(tick_row(65534, 0, 1, 0, 0, 0, 0));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        drain_pulses();
        write_reg(directed[i].reg_index, directed[i].reg_value);
      end else begin
        hand_pulses.push_back('{directed[i].typed, directed[i].pulse});
        send_tick(directed[i].tick);
      end
    end

    // run back to back at the longest tick, with no idling on either side
    apply_setting(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    idling_on = 1'b0;
    repeat (NO_IDLE_TICKS) send_tick(random_tick());
    idling_on = 1'b1;

    random_phase(16'd10000, 16'd1, 16'd0, 16'd0);
    random_phase(16'd1, 16'd1, 16'd1, 16'd5);
    random_phase(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    random_phase(16'd300, 16'd1, 16'hFFFE, 16'd2);
    random_phase(16'd7919, 16'd1, 16'd1, 16'd1);

    drain_pulses();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
